>>> design/assert_macros.svh
// assertion macros shared by the queue rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on the rising clock, off during reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/spq_pkg.sv
// types and constants of the sorted-list priority queue
// no dependencies; imported by stable_priority_queue_top
package spq_pkg;

    localparam int unsigned ID_W            = 16;
    localparam int unsigned PRI_W           = 4;
    localparam int unsigned OCC_W           = 5;
    localparam int unsigned PRIORITY_LEVELS = 16;
    localparam int unsigned PRI_MAX         = PRIORITY_LEVELS - 1;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_POP_RD    = 5'b00010,
        S_INS_CMP   = 5'b00100,
        S_INS_PLACE = 5'b01000,
        S_RESULT    = 5'b10000
    } state_t;

endpackage

>>> design/stable_priority_queue_top.sv
// sorted-list priority queue, single module with slot memory and walk sequencer
// depends on spq_pkg and assert_macros.svh
`include "assert_macros.svh"

// Bounded priority queue of up to QUEUE_DEPTH entries (identifier, priority), kept
// sorted from high to low priority in a circular slot memory; equal priorities leave
// in arrival order. Each request on the slave stream gives exactly one result transfer
// on the master stream. A pop reads the head slot before its result; a pop on an
// empty queue and an insert into a full or an empty queue go straight to the result;
// other inserts first walk past each stored entry of lower priority, moving it one
// slot toward the tail. The insert walk runs from the tail through one priority
// compare per cycle against the registered read port of the slot memory; pops only
// advance the head pointer. A finished result waits in the output register, and the
// next request is taken while it waits; only a further result stalls until the master
// side takes the first. Priorities at or above PRIORITY_LEVELS saturate to its top
// level. Slots are not cleared at reset and need no clearing pass, since only held
// entries are ever used.
module stable_priority_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,   // entry_id, entry_priority, zero pad
    input  logic [0:0]                      s_tuser,   // req_type
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata    // status, popped_valid, popped_id,
                                                       // popped_priority, occupancy, zero pad
);
    import spq_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // slot memory and its registered read port
    entry_t slot_reg [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   k_reg, k_next;         // walk position, offset from head
    entry_t          new_entry_reg, new_entry_next;

    // pending result
    status_t         res_status_reg, res_status_next;
    logic            res_valid_reg, res_valid_next;
    entry_t          res_entry_reg, res_entry_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [CW-1:0]   rd_off, wr_off;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    entry_t          wr_data;
    entry_t          in_entry;
    logic [PRI_W-1:0] in_pri;
    logic            keep_place;            // stored entry stays ahead of the new one

    // offset from head to physical slot, wrapped once at depth
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    // saturate the incoming priority to the supported levels
    always_comb begin
        in_pri = s_tdata[ID_W +: PRI_W];
        if (32'(in_pri) > PRI_MAX) begin
            in_pri = PRI_W'(PRI_MAX);
        end
        in_entry.id  = s_tdata[ID_W-1:0];
        in_entry.pri = in_pri;
    end

    assign keep_place = (rd_data_reg.pri >= new_entry_reg.pri);
    assign rd_addr    = slot_addr(head_reg, rd_off);
    assign wr_addr    = slot_addr(head_reg, wr_off);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        k_next          = k_reg;
        new_entry_next  = new_entry_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        rd_off          = '0;
        wr_off          = '0;
        wr_en           = 1'b0;
        wr_data         = in_entry;

        // master side took the waiting result
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                // read the head for a pop, the tail for an insert
                rd_off = (s_tuser[0] == REQ_POP) ? '0 : count_reg - CW'(1);
                if (s_tvalid) begin
                    res_status_next = STATUS_OK;
                    res_valid_next  = 1'b0;
                    res_entry_next  = '0;
                    new_entry_next  = in_entry;
                    k_next          = count_reg;
                    if (s_tuser[0] == REQ_POP) begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_RESULT;
                        end else begin
                            state_next = S_POP_RD;
                        end
                    end else if (count_reg == CW'(QUEUE_DEPTH)) begin
                        res_status_next = STATUS_FULL;
                        state_next      = S_RESULT;
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_off     = '0;
                        wr_data    = in_entry;
                        count_next = CW'(1);
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_INS_CMP;
                    end
                end
            end
            S_POP_RD: begin
                res_valid_next = 1'b1;
                res_entry_next = rd_data_reg;
                head_next      = slot_addr(head_reg, CW'(1));
                count_next     = count_reg - CW'(1);
                state_next     = S_RESULT;
            end
            S_INS_CMP: begin
                // slot k-1 is in the read register; fetch k-2 for the next step
                rd_off = k_reg - CW'(2);
                wr_en  = 1'b1;
                wr_off = k_reg;
                if (keep_place) begin
                    wr_data    = new_entry_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESULT;
                end else begin
                    wr_data = rd_data_reg;
                    k_next  = k_reg - CW'(1);
                    if (k_reg == CW'(1)) begin
                        state_next = S_INS_PLACE;
                    end
                end
            end
            S_INS_PLACE: begin
                // new entry goes to the head slot
                wr_en      = 1'b1;
                wr_off     = k_reg;
                wr_data    = new_entry_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({OCC_W'(count_reg), res_entry_reg.pri,
                                                res_entry_reg.id, res_valid_reg,
                                                res_status_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // slot memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        new_entry_reg  <= new_entry_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // checks
    `SPQ_ASSERT_NEVER(a_count_bound, aclk, aresetn, 32'(count_reg) > QUEUE_DEPTH, "count above depth")
    `SPQ_ASSERT_NEVER(a_walk_pos, aclk, aresetn, (state_reg == S_INS_CMP) && (k_reg == '0), "walk at head in compare")
    `SPQ_ASSERT(a_full_keeps, aclk, aresetn, (s_tvalid && s_tready && (s_tuser[0] == REQ_INSERT) && (count_reg == CW'(QUEUE_DEPTH))) |=> ((count_reg == $past(count_reg)) && (state_reg == S_RESULT)), "full insert changed queue")
    `SPQ_ASSERT(a_pop_head, aclk, aresetn, (state_reg == S_POP_RD) |=> (count_reg == $past(count_reg) - CW'(1)), "pop did not remove one entry")

endmodule
